// ===== rtl/core/ray_march_circle_occluder_core_macros.svh =====
// Assertion macros for the ray marcher checker.
// Needs a clock aclk and an active-low reset aresetn in the including scope.
`ifndef RAY_MARCH_CIRCLE_OCCLUDER_CORE_MACROS_SVH
`define RAY_MARCH_CIRCLE_OCCLUDER_CORE_MACROS_SVH

// Same-cycle implication, checked on every edge out of reset
`define RMCO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every edge out of reset
`define RMCO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rmco_pkg.sv =====
// Shared types, constants and direction-table math for the ray marcher.
// No dependencies; used by the direction ROM, the core and the checker.
package rmco_pkg;

    // Field widths
    localparam int POS_W  = 29;   // signed Q12.16 position
    localparam int FRAC_W = 16;
    localparam int DIR_W  = 18;   // signed Q1.16 direction
    localparam int PIX_W  = 12;
    localparam int COORD_W = 11;
    localparam int RAD_W  = 10;
    localparam int IDX_W  = 7;
    localparam int ROM_DEPTH = 2 ** IDX_W;

    // Item kinds on the input side
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_OBSTACLE_X      = 2'd0;
    localparam logic [1:0] CFG_OBSTACLE_Y      = 2'd1;
    localparam logic [1:0] CFG_OBSTACLE_RADIUS = 2'd2;

    localparam logic [COORD_W-1:0] OBSTACLE_X_RST      = 11'd650;
    localparam logic [COORD_W-1:0] OBSTACLE_Y_RST      = 11'd300;
    localparam logic [RAD_W-1:0]   OBSTACLE_RADIUS_RST = 10'd140;

    typedef enum logic [1:0] {
        ST_MARCH = 2'd0,
        ST_OFF   = 2'd1,
        ST_HIT   = 2'd2,
        ST_IDLE  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] cos_q;
        logic signed [DIR_W-1:0] sin_q;
    } dir_t;

    // Angle constants in Q30 (pi rounded to the nearest Q30 value)
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] ONE_Q16     = 64'd65536;

    // Taylor divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
    localparam logic [63:0] SIN_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
    localparam logic [63:0] COS_DIV [6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

    // Round a Q30 sum half away from zero to Q16, magnitude limited to one
    function automatic logic signed [DIR_W-1:0] q16_of(input logic signed [63:0] sum);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = sum[63];
        mag = neg ? 64'(-sum) : 64'(sum);
        q   = (mag + 64'd8192) >> 14;
        if (q > ONE_Q16) begin
            q = ONE_Q16;
        end
        return neg ? -$signed(q[DIR_W-1:0]) : $signed(q[DIR_W-1:0]);
    endfunction

    // Direction for a Q30 angle; only evaluated on constants to build the ROM
    function automatic dir_t rmco_dir(input logic [63:0] a);
        logic               sin_neg;
        logic               cos_neg;
        logic [63:0]        m;
        logic [63:0]        t;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] ssum;
        logic signed [63:0] csum;
        dir_t               d;
        sin_neg = a > PI_Q30;
        m       = sin_neg ? ((a > TWO_PI_Q30) ? 64'd0 : TWO_PI_Q30 - a) : a;
        cos_neg = m > HALF_PI_Q30;
        t       = cos_neg ? ((m > PI_Q30) ? 64'd0 : PI_Q30 - m) : m;
        x2      = (t * t) >> 30;
        // sine series through t^13
        term = t;
        ssum = $signed(t);
        for (int k = 0; k < 6; k++) begin
            term = ((term * x2) >> 30) / SIN_DIV[k];
            if (k % 2 == 0) ssum = ssum - $signed(term);
            else            ssum = ssum + $signed(term);
        end
        // cosine series through t^12
        term = 64'd1 << 30;
        csum = $signed(term);
        for (int k = 0; k < 6; k++) begin
            term = ((term * x2) >> 30) / COS_DIV[k];
            if (k % 2 == 0) csum = csum - $signed(term);
            else            csum = csum + $signed(term);
        end
        d.sin_q = q16_of(sin_neg ? -ssum : ssum);
        d.cos_q = q16_of(cos_neg ? -csum : csum);
        return d;
    endfunction

endpackage

// ===== rtl/core/ray_march_circle_occluder_core.sv =====
// Top level of the 2D ray marcher with one circular obstacle.
// Depends on rmco_pkg and rmco_dir_rom.
//
// Usage:
//   Input stream (s_*): s_tuser selects the item kind, 0 loads a ray
//   (start point and angle index in s_tdata), 1 advances the loaded ray one
//   unit step. A load gives no result; each advance gives exactly one.
//   Result stream (m_*): m_tdata holds the pixel under the new position,
//   m_tuser the step status (marching, left screen, hit, idle) and m_tlast
//   marks the step that ends the ray.
//   Config port (cfg_*): writes obstacle x, y and radius; always ready.
// Timing:
//   An item is first held in the input register; a step's result is then
//   loaded into the output register, which drives m_tvalid. One item per
//   clock is sustained while the output is not stalled: the position add, the
//   two 26x26 squarings and the radius compare are all combinational.
// Reset:
//   No ray is loaded, obstacle returns to (650, 300) with radius 140.
// Stall:
//   While m_tready is low the result holds; loads keep flowing, and a step
//   waits in the input register until the output register frees up.
module ray_march_circle_occluder_core import rmco_pkg::*; #(
    parameter int RAY_COUNT     = 100,
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // source_x[10:0], source_y[21:11], ray_index[28:22], zero
    input  logic         s_tuser,   // func
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // pixel_x[11:0], pixel_y[23:12]
    output logic [1:0]   m_tuser,   // step_status
    output logic         m_tlast,   // ray_done
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    localparam logic [POS_W-1:0] X_LIMIT = POS_W'(SCREEN_WIDTH * 65536);
    localparam logic [POS_W-1:0] Y_LIMIT = POS_W'(SCREEN_HEIGHT * 65536);
    localparam int DIST_W = POS_W + 1;
    localparam int SQ_IN_W = FRAC_W + RAD_W;          // larger offsets cannot hit
    localparam int SQ_W = 2 * SQ_IN_W;

    // configuration registers
    logic [COORD_W-1:0]  obst_x_reg;
    logic [COORD_W-1:0]  obst_y_reg;
    logic [RAD_W-1:0]    obst_r_reg;
    logic [2*RAD_W-1:0]  r_sq_reg;

    // input register
    logic                in_valid_reg;
    logic                in_func_reg;
    logic [COORD_W-1:0]  in_src_x_reg;
    logic [COORD_W-1:0]  in_src_y_reg;
    logic [IDX_W-1:0]    in_idx_reg;

    // ray state
    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;
    dir_t                    dir_reg;
    logic                    active_reg;

    // output register
    logic                m_valid_reg;
    logic [PIX_W-1:0]    m_pix_x_reg;
    logic [PIX_W-1:0]    m_pix_y_reg;
    status_t             m_status_reg;
    logic                m_done_reg;

    dir_t                    rom_dir;
    logic                    out_free;
    logic                    advance;
    logic                    is_step;
    logic signed [POS_W-1:0] pos_x_next;
    logic signed [POS_W-1:0] pos_y_next;
    logic                    off_screen;
    logic [DIST_W-1:0]       dx;
    logic [DIST_W-1:0]       dy;
    logic [DIST_W-1:0]       mag_x;
    logic [DIST_W-1:0]       mag_y;
    logic                    far_x;
    logic                    far_y;
    logic [SQ_W-1:0]         sq_x;
    logic [SQ_W-1:0]         sq_y;
    logic [SQ_W:0]           dist_sq;
    logic                    hit;
    status_t                 status_next;

    rmco_dir_rom #(
        .RAY_COUNT (RAY_COUNT)
    ) u_dir_rom (
        .ray_index (in_idx_reg),
        .dir       (rom_dir)
    );

    // handshake: loads always move on, steps need a free output register
    assign out_free  = !m_valid_reg || m_tready;
    assign is_step   = (in_func_reg == FUNC_STEP);
    assign advance   = in_valid_reg && (!is_step || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // one unit step along the stored direction
    always_comb begin
        pos_x_next = pos_x_reg + POS_W'(dir_reg.cos_q);
        pos_y_next = pos_y_reg + POS_W'(dir_reg.sin_q);
    end

    // screen bounds on the exact Q16 position
    always_comb begin
        off_screen = pos_x_next[POS_W-1] || ({1'b0, pos_x_next[POS_W-2:0]} > X_LIMIT) ||
                     pos_y_next[POS_W-1] || ({1'b0, pos_y_next[POS_W-2:0]} > Y_LIMIT);
    end

    // squared distance to the obstacle centre, Q32
    always_comb begin
        dx = {pos_x_next[POS_W-1], pos_x_next} - {3'b000, obst_x_reg, FRAC_W'(0)};
        dy = {pos_y_next[POS_W-1], pos_y_next} - {3'b000, obst_y_reg, FRAC_W'(0)};
        mag_x = dx[DIST_W-1] ? -dx : dx;
        mag_y = dy[DIST_W-1] ? -dy : dy;
        far_x = |mag_x[DIST_W-1:SQ_IN_W];
        far_y = |mag_y[DIST_W-1:SQ_IN_W];
        sq_x = mag_x[SQ_IN_W-1:0] * mag_x[SQ_IN_W-1:0];
        sq_y = mag_y[SQ_IN_W-1:0] * mag_y[SQ_IN_W-1:0];
        dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
        // r^2 in Q32 has zero low bits, so compare the whole-pixel part
        hit = !far_x && !far_y &&
              (dist_sq[SQ_W:2*FRAC_W] < {1'b0, r_sq_reg});
    end

    always_comb begin
        if (!active_reg) begin
            status_next = ST_IDLE;
        end else if (hit) begin
            status_next = ST_HIT;
        end else if (off_screen) begin
            status_next = ST_OFF;
        end else begin
            status_next = ST_MARCH;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obst_x_reg <= OBSTACLE_X_RST;
            obst_y_reg <= OBSTACLE_Y_RST;
            obst_r_reg <= OBSTACLE_RADIUS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OBSTACLE_X:      obst_x_reg <= cfg_data;
                CFG_OBSTACLE_Y:      obst_y_reg <= cfg_data;
                CFG_OBSTACLE_RADIUS: obst_r_reg <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // radius squared is registered, following the radius register in the next cycle
    always_ff @(posedge aclk) begin
        r_sq_reg <= obst_r_reg * obst_r_reg;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg  <= s_tuser;
            in_src_x_reg <= s_tdata[10:0];
            in_src_y_reg <= s_tdata[21:11];
            in_idx_reg   <= s_tdata[28:22];
        end
    end

    // ray state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (advance) begin
            if (!is_step) begin
                active_reg <= 1'b1;
            end else if (status_next == ST_HIT || status_next == ST_OFF) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (!is_step) begin
                pos_x_reg <= {2'b00, in_src_x_reg, FRAC_W'(0)};
                pos_y_reg <= {2'b00, in_src_y_reg, FRAC_W'(0)};
                dir_reg   <= rom_dir;
            end else if (active_reg) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && is_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_step) begin
            m_status_reg <= status_next;
            if (active_reg) begin
                m_pix_x_reg <= pos_x_next[FRAC_W+PIX_W-1:FRAC_W];
                m_pix_y_reg <= pos_y_next[FRAC_W+PIX_W-1:FRAC_W];
                m_done_reg  <= (status_next != ST_MARCH);
            end else begin
                m_pix_x_reg <= '0;
                m_pix_y_reg <= '0;
                m_done_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_y_reg, m_pix_x_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_done_reg;

endmodule

// ===== rtl/core/rmco_dir_rom.sv =====
// Direction ROM: maps a 7-bit ray index (reduced modulo RAY_COUNT) to cos/sin.
// Depends on rmco_pkg for dir_t and the table math.
module rmco_dir_rom import rmco_pkg::*; #(
    parameter int RAY_COUNT = 100
) (
    input  logic [IDX_W-1:0] ray_index,
    output dir_t             dir
);

    dir_t rom_w [ROM_DEPTH];

    // Each entry is built at elaboration; the index wraps at RAY_COUNT
    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam logic [63:0] IDX = 64'(g % RAY_COUNT);
        localparam logic [63:0] ANG =
            (IDX * 64'd628 * 64'd1073741824 + 64'(50 * RAY_COUNT)) / 64'(100 * RAY_COUNT);
        localparam dir_t ENTRY = rmco_dir(ANG);
        assign rom_w[g] = ENTRY;
    end

    assign dir = rom_w[ray_index];

endmodule

// ===== rtl/core/rmco_checker.sv =====
// Port-level checks for the ray marcher, bound to the top level.
// Depends on rmco_pkg and ray_march_circle_occluder_core_macros.svh.
`include "ray_march_circle_occluder_core_macros.svh"

module rmco_checker import rmco_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // end of ray exactly on the off-screen and hit statuses
    `RMCO_ASSERT_NOW(a_last_matches_status, m_tvalid,
        m_tlast == (m_tuser == ST_OFF || m_tuser == ST_HIT), "tlast disagrees with step status")

    // an idle step carries a zero pixel and never ends a ray
    `RMCO_ASSERT_NOW(a_idle_is_zero, m_tvalid && m_tuser == ST_IDLE,
        m_tdata == 24'd0 && !m_tlast, "idle result not zero")

    // a new result must trace back to an accepted item (input reg, then output reg)
    `RMCO_ASSERT_NOW(a_result_has_source, $rose(m_tvalid),
        $past(s_tvalid && s_tready, 2), "result without accepted item")

    // stalled result holds still
    `RMCO_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result changed")

endmodule

bind ray_march_circle_occluder_core rmco_checker u_rmco_checker (.*);
